/* rtl/dcl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcl_pkg
// Shared constants, types and codes for the dual bus unit liveness monitor.
// ----------------------------------------------------------------------------
package dcl_pkg;

  // Default table size and configuration reset values
  localparam int unsigned UnitsDefault     = 17;
  localparam logic [4:0]  SelfSlotReset    = 5'd0;
  localparam logic [15:0] JudgePeriodReset = 16'd1000;

  // Field widths
  localparam int unsigned ActionW = 2;
  localparam int unsigned SlotW   = 5;
  localparam int unsigned PeriodW = 16;
  localparam int unsigned CountW  = 5;
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 16;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;

  // Action codes; code three is a no-op that only reports the counts
  localparam logic [ActionW-1:0] ActReply = 2'd0;
  localparam logic [ActionW-1:0] ActTick  = 2'd1;
  localparam logic [ActionW-1:0] ActQuery = 2'd2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegSelfSlot    = 1'd0;
  localparam logic [CfgIdxW-1:0] RegJudgePeriod = 1'd1;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_APPLY,
    ST_COUNT,
    ST_HOLD
  } dcl_state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;    // latch the accepted item
    logic apply;      // update the tables and clear the counters
    logic count_step; // add one table entry to each good count
    logic load_out;   // move the result into the output register
  } dcl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic count_last; // the entry being counted is the last one
  } dcl_sts_t;

endpackage

/* rtl/dual_can_unit_liveness_monitor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_can_unit_liveness_monitor
// Liveness table for units on a redundant pair of CAN buses.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: tuser carries the action (reply heard, tick, query);
//   tdata carries slot, channel and the two local controller active flags.
//   Output stream: one transaction per input transaction with the query
//   answer, the good counts of both buses and the judge flag.
//   Configuration channel: index 0 writes self_slot, index 1 judge_period;
//   always ready, write only while no transaction is in flight.
// Sequence:
//   An accepted item is first applied to the tables, then a walk of one
//   table entry per cycle counts the good units on both buses, then the
//   result is loaded into the output register. The block is ready for the
//   next item in the cycle after the result is loaded, and does not accept
//   a new item before it has loaded the result of the last one.
// Reset: every unit is good on both buses, no unit heard, tick count zero,
//   configuration at self_slot 0 and judge_period 1000.
// Stall: a waiting result sits in the output register while the next item
//   is accepted and processed; that item then holds until the register frees.
// ----------------------------------------------------------------------------
module dual_can_unit_liveness_monitor #(
  parameter int unsigned UNITS = dcl_pkg::UnitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [4:0] slot, [5] channel, [6] bus0_active, [7] bus1_active
  input  logic [dcl_pkg::InDataW-1:0]   s_axis_tdata,
  // [1:0] action
  input  logic [dcl_pkg::ActionW-1:0]   s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [0] unit_ok, [5:1] bus0_good_count, [10:6] bus1_good_count, [11] judged
  output logic [dcl_pkg::OutDataW-1:0]  m_axis_tdata,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [dcl_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [dcl_pkg::CfgDataW-1:0]  cfg_data_i
);

  dcl_pkg::dcl_cmd_t cmd;
  dcl_pkg::dcl_sts_t sts;

  assign cfg_ready_o = 1'b1;

  dcl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  dcl_dp #(
    .UNITS (UNITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (s_axis_tdata),
    .in_action_i (s_axis_tuser),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_data_o  (m_axis_tdata)
  );

endmodule

/* rtl/dcl_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcl_ctrl
// Sequencer: accepts one item, applies it, walks the table to count good
// units, then hands the result to the output register.
// ----------------------------------------------------------------------------
module dcl_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  dcl_pkg::dcl_sts_t sts_i,
  output dcl_pkg::dcl_cmd_t cmd_o
);

  dcl_pkg::dcl_state_e state_q, state_d;
  logic                out_valid_q, out_valid_d;
  logic                in_fire;
  logic                out_free;

  assign in_ready_o  = (state_q == dcl_pkg::ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  // Hold state and result flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dcl_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      dcl_pkg::ST_IDLE: begin
        if (in_fire) begin
          cmd_o.capture = 1'b1;
          state_d       = dcl_pkg::ST_APPLY;
        end
      end
      dcl_pkg::ST_APPLY: begin
        cmd_o.apply = 1'b1;
        state_d     = dcl_pkg::ST_COUNT;
      end
      dcl_pkg::ST_COUNT: begin
        cmd_o.count_step = 1'b1;
        if (sts_i.count_last) begin
          state_d = dcl_pkg::ST_HOLD;
        end
      end
      dcl_pkg::ST_HOLD: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = dcl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = dcl_pkg::ST_IDLE;
      end
    endcase
  end

  // An accepted item is always applied next
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == dcl_pkg::ST_APPLY)
    else $error("accepted item not applied");

  // Never overwrite a result still waiting at the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten");

  // The count walk ends on the last entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dcl_pkg::ST_COUNT && sts_i.count_last) |=> state_q == dcl_pkg::ST_HOLD)
    else $error("count walk did not finish");

endmodule

/* rtl/dcl_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcl_dp
// Datapath: status and heard tables, tick counter, configuration registers,
// bit-serial good counters and the output register.
// ----------------------------------------------------------------------------
module dcl_dp #(
  parameter int unsigned UNITS = dcl_pkg::UnitsDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  dcl_pkg::dcl_cmd_t              cmd_i,
  output dcl_pkg::dcl_sts_t              sts_o,
  input  logic [dcl_pkg::InDataW-1:0]    in_data_i,
  input  logic [dcl_pkg::ActionW-1:0]    in_action_i,
  input  logic                           cfg_valid_i,
  input  logic [dcl_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [dcl_pkg::CfgDataW-1:0]   cfg_data_i,
  output logic [dcl_pkg::OutDataW-1:0]   out_data_o
);

  localparam int unsigned IdxW = (UNITS > 1) ? $clog2(UNITS) : 1;
  localparam int unsigned AccW = $clog2(UNITS + 1);
  localparam int unsigned CmpW = dcl_pkg::SlotW + 1;

  // Configuration
  logic [dcl_pkg::SlotW-1:0]   self_slot_q;
  logic [dcl_pkg::PeriodW-1:0] judge_period_q;

  // Latched item
  logic [dcl_pkg::ActionW-1:0] action_q;
  logic [dcl_pkg::SlotW-1:0]   slot_q;
  logic                        channel_q;
  logic                        act0_q, act1_q;

  // Tables and counters
  logic [UNITS-1:0]            st0_q, st1_q, hd0_q, hd1_q;
  logic [dcl_pkg::PeriodW-1:0] ticks_q;
  logic [IdxW-1:0]             idx_q;
  logic [AccW-1:0]             acc0_q, acc1_q;
  logic                        res_ok_q, res_judged_q;
  logic [dcl_pkg::OutDataW-1:0] out_q;

  logic                        slot_hit, self_hit, judge_now;
  logic [UNITS-1:0]            slot_mask, own_mask;
  logic [dcl_pkg::PeriodW-1:0] tick_inc;

  // Decode slots into table masks; out-of-table slots select nothing
  assign slot_hit  = CmpW'(slot_q) < CmpW'(UNITS);
  assign self_hit  = CmpW'(self_slot_q) < CmpW'(UNITS);
  assign slot_mask = slot_hit ? (UNITS'(1) << slot_q) : '0;
  assign own_mask  = self_hit ? (UNITS'(1) << self_slot_q) : '0;

  // Saturating tick count and period check
  assign tick_inc  = (ticks_q != '1) ? ticks_q + 1'b1 : ticks_q;
  assign judge_now = tick_inc >= judge_period_q;

  assign sts_o.count_last = (idx_q == IdxW'(UNITS - 1));
  assign out_data_o       = out_q;

  // Take configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      self_slot_q    <= dcl_pkg::SelfSlotReset;
      judge_period_q <= dcl_pkg::JudgePeriodReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        dcl_pkg::RegSelfSlot:    self_slot_q    <= cfg_data_i[dcl_pkg::SlotW-1:0];
        dcl_pkg::RegJudgePeriod: judge_period_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Latch the accepted transaction
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      action_q  <= in_action_i;
      slot_q    <= in_data_i[4:0];
      channel_q <= in_data_i[5];
      act0_q    <= in_data_i[6];
      act1_q    <= in_data_i[7];
    end
  end

  // Apply replies, ticks and judge passes to the tables
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st0_q   <= '1;
      st1_q   <= '1;
      hd0_q   <= '0;
      hd1_q   <= '0;
      ticks_q <= '0;
    end else if (cmd_i.apply) begin
      case (action_q)
        dcl_pkg::ActReply: begin
          if (channel_q) begin
            st1_q <= st1_q | slot_mask;
            hd1_q <= hd1_q | slot_mask;
          end else begin
            st0_q <= st0_q | slot_mask;
            hd0_q <= hd0_q | slot_mask;
          end
        end
        dcl_pkg::ActTick: begin
          if (judge_now) begin
            ticks_q <= '0;
            st0_q   <= (hd0_q & ~own_mask) | (act0_q ? own_mask : '0);
            st1_q   <= (hd1_q & ~own_mask) | (act1_q ? own_mask : '0);
            hd0_q   <= hd0_q & own_mask;
            hd1_q   <= hd1_q & own_mask;
          end else begin
            ticks_q <= tick_inc;
          end
        end
        default: ;
      endcase
    end
  end

  // Record the per-item flags
  always_ff @(posedge clk_i) begin
    if (cmd_i.apply) begin
      res_ok_q     <= (action_q == dcl_pkg::ActQuery) && |((st0_q | st1_q) & slot_mask);
      res_judged_q <= (action_q == dcl_pkg::ActTick) && judge_now;
    end
  end

  // Walk the tables one entry a cycle and count good units
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      acc0_q <= '0;
      acc1_q <= '0;
    end else if (cmd_i.apply) begin
      idx_q  <= '0;
      acc0_q <= '0;
      acc1_q <= '0;
    end else if (cmd_i.count_step) begin
      idx_q  <= idx_q + 1'b1;
      acc0_q <= acc0_q + AccW'(st0_q[idx_q]);
      acc1_q <= acc1_q + AccW'(st1_q[idx_q]);
    end
  end

  // Load the output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q <= {4'b0000, res_judged_q, dcl_pkg::CountW'(acc1_q),
                dcl_pkg::CountW'(acc0_q), res_ok_q};
    end
  end

  // Counts never exceed the table size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc0_q <= AccW'(UNITS)) && (acc1_q <= AccW'(UNITS)))
    else $error("good count above table size");

  // A judge pass leaves the tick counter at zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.apply && action_q == dcl_pkg::ActTick && judge_now) |=> ticks_q == '0)
    else $error("tick counter not cleared by judge pass");

endmodule

/* tb/tb_dual_can_unit_liveness_monitor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dual_can_unit_liveness_monitor
// Self-checking bench for the dual bus unit liveness monitor. A behavioural
// liveness table predicts every result from the accepted input transactions.
// The bench then compares each output transaction field by field against the
// oldest prediction. Directed cases cover the table edges, the own slot and
// the judge pass. Random traffic follows, with and without sender and receiver stalls.
// ----------------------------------------------------------------------------
module tb_dual_can_unit_liveness_monitor;

  localparam int unsigned UNITS      = dcl_pkg::UnitsDefault;
  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned MaxPrinted = 100;
  // Action code three is spare: it only reports the counts
  localparam logic [dcl_pkg::ActionW-1:0] ActSpare = 2'd3;

  typedef struct packed {
    logic                       unit_ok;
    logic [dcl_pkg::CountW-1:0] bus0_count;
    logic [dcl_pkg::CountW-1:0] bus1_count;
    logic                       judged;
  } liveness_result_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [dcl_pkg::InDataW-1:0]   s_axis_tdata = '0;
  logic [dcl_pkg::ActionW-1:0]   s_axis_tuser = '0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [dcl_pkg::OutDataW-1:0]  m_axis_tdata;
  logic                          cfg_valid_i = 1'b0;
  logic                          cfg_ready_o;
  logic [dcl_pkg::CfgIdxW-1:0]   cfg_index_i = '0;
  logic [dcl_pkg::CfgDataW-1:0]  cfg_data_i = '0;

  // Predicted liveness table and configuration
  logic [UNITS-1:0]              good0;
  logic [UNITS-1:0]              good1;
  logic [UNITS-1:0]              heard0;
  logic [UNITS-1:0]              heard1;
  logic [dcl_pkg::PeriodW-1:0]   tick_count;
  logic [dcl_pkg::SlotW-1:0]     own_slot;
  logic [dcl_pkg::PeriodW-1:0]   period_ticks;

  liveness_result_t     pending_results[$];
  int unsigned          error_count = 0;
  int unsigned          cycle_count = 0;
  int unsigned          send_idle_pct = 33;
  int unsigned          recv_idle_pct = 66;

  dual_can_unit_liveness_monitor #(
    .UNITS(UNITS)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Clock: 12 ns period
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("tb_dual_can_unit_liveness_monitor: FAIL");
      $finish;
    end
  end

  // Stall the result stream at random
  always @(negedge clk_i) begin
    m_axis_tready = ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    error_count++;
    if (error_count <= MaxPrinted)
      $display("MISMATCH %s: expected %0d, got %0d", what, want, got);
  endtask

  // Apply one transaction to the predicted table and return its result
  function automatic liveness_result_t predict_liveness(
      input logic [dcl_pkg::ActionW-1:0] action,
      input logic [dcl_pkg::SlotW-1:0]   slot,
      input logic                        channel,
      input logic                        act0,
      input logic                        act1);
    liveness_result_t res;
    logic [UNITS-1:0] sel;
    logic [UNITS-1:0] own;
    res = '0;
    sel = '0;
    own = '0;
    if (slot < UNITS) sel[slot] = 1'b1;
    if (own_slot < UNITS) own[own_slot] = 1'b1;
    case (action)
      dcl_pkg::ActReply: begin
        if (channel) begin
          good1  = good1 | sel;
          heard1 = heard1 | sel;
        end else begin
          good0  = good0 | sel;
          heard0 = heard0 | sel;
        end
      end
      dcl_pkg::ActTick: begin
        if (tick_count != '1) tick_count = tick_count + 1'b1;
        if (tick_count >= period_ticks) begin
          tick_count = '0;
          good0  = (heard0 & ~own) | (act0 ? own : '0);
          good1  = (heard1 & ~own) | (act1 ? own : '0);
          heard0 = heard0 & own;
          heard1 = heard1 & own;
          res.judged = 1'b1;
        end
      end
      dcl_pkg::ActQuery: begin
        res.unit_ok = |((good0 | good1) & sel);
      end
      default: begin
      end
    endcase
    res.bus0_count = dcl_pkg::CountW'($countones(good0));
    res.bus1_count = dcl_pkg::CountW'($countones(good1));
    return res;
  endfunction

  // Send one input transaction; entered and left just after a falling edge
  task automatic send_event(input logic [dcl_pkg::ActionW-1:0] action,
                            input logic [dcl_pkg::SlotW-1:0]   slot,
                            input logic channel, input logic act0, input logic act1);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = action;
    s_axis_tdata  = {act1, act0, channel, slot};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_results.push_back(predict_liveness(action, slot, channel, act0, act1));
    @(negedge clk_i);
  endtask

  // Hold off until every predicted result has arrived
  task automatic wait_drained();
    s_axis_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Write one register while the block is idle
  task automatic write_register(input logic [dcl_pkg::CfgIdxW-1:0] index,
                                input logic [dcl_pkg::CfgDataW-1:0] value);
    wait_drained();
    repeat (4) @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = index;
    cfg_data_i  = value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (index == dcl_pkg::RegSelfSlot) own_slot = value[dcl_pkg::SlotW-1:0];
    else period_ticks = value;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Check each result transaction against the oldest prediction
  always @(posedge clk_i) begin : result_check
    liveness_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with none pending", 0, 32'(m_axis_tdata));
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[0] !== want.unit_ok)
          report_mismatch("unit_ok", 32'(want.unit_ok), 32'(m_axis_tdata[0]));
        if (m_axis_tdata[5:1] !== want.bus0_count)
          report_mismatch("bus0_good_count", 32'(want.bus0_count),
                          32'(m_axis_tdata[5:1]));
        if (m_axis_tdata[10:6] !== want.bus1_count)
          report_mismatch("bus1_good_count", 32'(want.bus1_count),
                          32'(m_axis_tdata[10:6]));
        if (m_axis_tdata[11] !== want.judged)
          report_mismatch("judged", 32'(want.judged), 32'(m_axis_tdata[11]));
      end
    end
  end

  // Table edges, out-of-table slots and the spare action after reset
  task automatic test_reset_defaults();
    send_event(dcl_pkg::ActQuery, 5'd0, 1'b0, 1'b0, 1'b0);
    send_event(dcl_pkg::ActQuery, 5'd16, 1'b0, 1'b0, 1'b0);
    send_event(dcl_pkg::ActQuery, 5'd17, 1'b1, 1'b1, 1'b1);
    send_event(dcl_pkg::ActQuery, 5'd31, 1'b0, 1'b0, 1'b0);
    send_event(ActSpare, 5'd31, 1'b1, 1'b1, 1'b1);
    send_event(dcl_pkg::ActReply, 5'd0, 1'b0, 1'b0, 1'b0);
    send_event(dcl_pkg::ActReply, 5'd16, 1'b1, 1'b0, 1'b0);
    send_event(dcl_pkg::ActReply, 5'd17, 1'b0, 1'b0, 1'b0);
    send_event(dcl_pkg::ActReply, 5'd31, 1'b1, 1'b1, 1'b1);
    send_event(dcl_pkg::ActQuery, 5'd0, 1'b0, 1'b0, 1'b0);
  endtask

  // Judge passes: own slot from local activity, repeated replies, period change
  task automatic test_judge_pass();
    write_register(dcl_pkg::RegSelfSlot, 16'd16);
    write_register(dcl_pkg::RegJudgePeriod, 16'd1);
    send_event(dcl_pkg::ActTick, 5'd0, 1'b0, 1'b1, 1'b0);
    send_event(dcl_pkg::ActQuery, 5'd0, 1'b0, 1'b0, 1'b0);
    send_event(dcl_pkg::ActQuery, 5'd16, 1'b0, 1'b0, 1'b0);
    send_event(dcl_pkg::ActReply, 5'd16, 1'b0, 1'b0, 1'b0);
    send_event(dcl_pkg::ActReply, 5'd5, 1'b1, 1'b0, 1'b0);
    send_event(dcl_pkg::ActReply, 5'd5, 1'b1, 1'b0, 1'b0);
    send_event(dcl_pkg::ActTick, 5'd0, 1'b0, 1'b0, 1'b1);
    send_event(dcl_pkg::ActQuery, 5'd5, 1'b0, 1'b0, 1'b0);
    send_event(dcl_pkg::ActQuery, 5'd16, 1'b0, 1'b0, 1'b0);
    write_register(dcl_pkg::RegSelfSlot, 16'd0);
    write_register(dcl_pkg::RegJudgePeriod, 16'd2);
    send_event(dcl_pkg::ActTick, 5'd0, 1'b0, 1'b1, 1'b1);
    send_event(dcl_pkg::ActTick, 5'd0, 1'b0, 1'b0, 1'b0);
    send_event(dcl_pkg::ActQuery, 5'd0, 1'b0, 1'b0, 1'b0);
  endtask

  // Longest period: ticks accumulate without a judge pass until the period drops to one
  task automatic test_period_extremes();
    write_register(dcl_pkg::RegJudgePeriod, 16'hFFFF);
    write_register(dcl_pkg::RegSelfSlot, 16'd16);
    repeat (6) send_event(dcl_pkg::ActTick, 5'd0, 1'b0, 1'b1, 1'b1);
    send_event(dcl_pkg::ActQuery, 5'd3, 1'b0, 1'b0, 1'b0);
    write_register(dcl_pkg::RegJudgePeriod, 16'd1);
    send_event(dcl_pkg::ActTick, 5'd0, 1'b0, 1'b1, 1'b0);
  endtask

  // Mixed random traffic, reconfigured now and then between bursts
  task automatic test_random_traffic(input int unsigned n_items,
                                     input int unsigned send_pct,
                                     input int unsigned recv_pct);
    int unsigned pick;
    logic [dcl_pkg::ActionW-1:0] action;
    logic [dcl_pkg::SlotW-1:0] slot;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int unsigned i = 0; i < n_items; i++) begin
      if (i % 150 == 0) begin
        pick = $urandom_range(9);
        write_register(dcl_pkg::RegSelfSlot, (pick == 0) ? 16'd0 :
                                    (pick == 1) ? 16'd16 : 16'($urandom_range(16)));
        pick = $urandom_range(99);
        write_register(dcl_pkg::RegJudgePeriod, (pick < 10) ? 16'd1 :
                                       (pick < 80) ? 16'($urandom_range(2, 10)) :
                                       (pick < 95) ? 16'($urandom_range(11, 40)) : 16'd1000);
      end
      // Drain the pipe once per burst, and now and then at random
      if (i == n_items / 2 || $urandom_range(99) == 0) wait_drained();
      pick = $urandom_range(99);
      action = (pick < 40) ? dcl_pkg::ActReply : (pick < 70) ? dcl_pkg::ActTick :
               (pick < 95) ? dcl_pkg::ActQuery : ActSpare;
      slot = ($urandom_range(99) < 85) ? dcl_pkg::SlotW'($urandom_range(UNITS - 1))
                                       : dcl_pkg::SlotW'($urandom_range(31, UNITS));
      send_event(action, slot, 1'($urandom), 1'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    good0        = '1;
    good1        = '1;
    heard0       = '0;
    heard1       = '0;
    tick_count   = '0;
    own_slot     = dcl_pkg::SelfSlotReset;
    period_ticks = dcl_pkg::JudgePeriodReset;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_defaults();
    test_judge_pass();
    test_period_extremes();
    test_random_traffic(630, 33, 66);
    test_random_traffic(630, 66, 33);
    test_random_traffic(630, 0, 0);

    // Let the last results out, then allow for anything stray
    wait_drained();
    repeat (UNITS + 8) @(posedge clk_i);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("tb_dual_can_unit_liveness_monitor: PASS");
    end else begin
      $display("tb_dual_can_unit_liveness_monitor: FAIL");
    end
    $finish;
  end

endmodule
